@@ hdl/utf8_dec_pkg.sv @@
// shared types and constants for the utf-8 stream decoder
package utf8_dec_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int CP_WIDTH     = 31;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 3;

   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [CP_WIDTH-1:0]     code_point_type;
   typedef logic [BYTE_WIDTH-1:0]   byte_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;

   localparam status_type ST_READY      = 2'd0;
   localparam status_type ST_MORE       = 2'd1;
   localparam status_type ST_INCOMPLETE = 2'd2;
   localparam status_type ST_BADSTART   = 2'd3;

endpackage

@@ hdl/utf8_stream_decoder_unit.sv @@
// utf-8 stream decoder top level: legacy 1 to 6 byte sequences, 31-bit code points
//
// usage
//   input channel req_*: one raw byte per transfer on req_in_byte
//   result channel rsp_*: one status and code point per input byte, in order
//   rsp_status: ready, need more, incomplete sequence, bad start byte
//   rsp_code_point holds the character when status is ready, else zero
// timing
//   an input register and a result register with the decode between them
//   each input byte passes from the input register through the decode into the result register
//   throughput is one byte per cycle while rsp_stall is low, set by the single decode stage
//   that updates the continuation count and accumulator in the same cycle
// reset
//   synchronous reset empties both registers and clears the sequence state
// stall
//   a stalled result holds; the input register still fills behind it and
//   req_stall rises only when both registers hold data and rsp_stall is high
module utf8_stream_decoder_unit
   import utf8_dec_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  byte_type       req_in_byte,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output status_type     rsp_status,
   output code_point_type rsp_code_point
);

   logic           in_valid_ff, in_valid_in;
   byte_type       in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   status_type     out_status_ff, out_status_in;
   code_point_type out_cp_ff, out_cp_in;
   count_type      remain_ff, remain_in;
   code_point_type acc_ff, acc_in;

   logic out_free;
   logic in_free;
   logic advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = !in_free;

   assign in_valid_in  = (req_valid && in_free) ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   // decode of one byte against the open sequence
   always_comb begin
      byte_type b;
      b             = in_byte_ff;
      remain_in     = remain_ff;
      acc_in        = acc_ff;
      out_status_in = ST_MORE;
      out_cp_in     = '0;
      if (remain_ff != '0) begin
         if (b[7:6] == 2'b10) begin
            remain_in = remain_ff - 3'd1;
            acc_in    = {acc_ff[CP_WIDTH-7:0], b[5:0]};
            if (remain_ff == 3'd1) begin
               out_status_in = ST_READY;
               out_cp_in     = {acc_ff[CP_WIDTH-7:0], b[5:0]};
            end
         end else begin
            remain_in     = '0;
            acc_in        = '0;
            out_status_in = ST_INCOMPLETE;
         end
      end else if (b inside {[8'h00:8'h7F]}) begin
         out_status_in = ST_READY;
         out_cp_in     = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, b};
      end else if (b inside {[8'hC0:8'hDF]}) begin
         remain_in = 3'd1;
         acc_in    = {{(CP_WIDTH-5){1'b0}}, b[4:0]};
      end else if (b inside {[8'hE0:8'hEF]}) begin
         remain_in = 3'd2;
         acc_in    = {{(CP_WIDTH-4){1'b0}}, b[3:0]};
      end else if (b inside {[8'hF0:8'hF7]}) begin
         remain_in = 3'd3;
         acc_in    = {{(CP_WIDTH-3){1'b0}}, b[2:0]};
      end else if (b inside {[8'hF8:8'hFB]}) begin
         remain_in = 3'd4;
         acc_in    = {{(CP_WIDTH-2){1'b0}}, b[1:0]};
      end else if (b inside {[8'hFC:8'hFD]}) begin
         remain_in = 3'd5;
         acc_in    = {{(CP_WIDTH-1){1'b0}}, b[0]};
      end else begin
         out_status_in = ST_BADSTART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remain_ff    <= '0;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            remain_ff <= remain_in;
            acc_ff    <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_status_ff <= out_status_in;
         out_cp_ff     <= out_cp_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_code_point = out_cp_ff;

endmodule

@@ hdl/utf8_dec_checker.sv @@
// port-level checks for the utf-8 stream decoder, bound to the top level
module utf8_dec_checker
   import utf8_dec_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_stall,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input status_type     rsp_status,
   input code_point_type rsp_code_point
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // code point only carried on a ready status
   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_READY) |-> rsp_code_point == '0)
      else $error("nonzero code point without ready status");

   // input never stalls while the result side is free
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (req_stall) |-> (rsp_valid && rsp_stall))
      else $error("input stalled while results can move");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_code_point)))
      else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_unit utf8_dec_checker u_utf8_dec_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_code_point (rsp_code_point)
);

@@ sim/testbench.sv @@
// testbench for the utf-8 stream decoder: predicts each result and checks it in order
`timescale 1ns / 100ps

module testbench;
   import utf8_dec_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      status_type     status;
      code_point_type code_point;
   } decode_type;

   typedef enum logic [0:0] {STALL_NONE, STALL_RANDOM} stall_mode_type;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   byte_type   req_in_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   status_type rsp_status;
   code_point_type rsp_code_point;

   // decoder state as the predictor sees it
   count_type      seq_left = '0;
   code_point_type seq_bits = '0;
   decode_type     decode_queue[$];

   bit             gaps_on      = 1'b0;
   stall_mode_type stall_mode   = STALL_NONE;
   int             hold_request = 0;
   int             stall_left   = 0;

   int cycle_count    = 0;
   int fail_count     = 0;
   int bytes_sent     = 0;
   int stalled_offers = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   utf8_stream_decoder_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_code_point (rsp_code_point)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, decode_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic decode_type decode_next_byte(byte_type b);
      decode_type r;
      r.status     = ST_MORE;
      r.code_point = '0;
      if (seq_left != 0) begin
         if (b[7:6] == 2'b10) begin
            seq_left = seq_left - 1'b1;
            seq_bits = {seq_bits[CP_WIDTH-7:0], b[5:0]};
            if (seq_left == 0) begin
               r.status     = ST_READY;
               r.code_point = seq_bits;
            end
         end else begin
            // breaking byte is dropped, not taken as a new lead
            seq_left = '0;
            seq_bits = '0;
            r.status = ST_INCOMPLETE;
         end
      end else if (!b[7]) begin
         r.status     = ST_READY;
         r.code_point = code_point_type'(b);
      end else if (b[7:5] == 3'b110) begin
         seq_left = 3'd1;
         seq_bits = code_point_type'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         seq_left = 3'd2;
         seq_bits = code_point_type'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         seq_left = 3'd3;
         seq_bits = code_point_type'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
         seq_left = 3'd4;
         seq_bits = code_point_type'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
         seq_left = 3'd5;
         seq_bits = code_point_type'(b[0]);
      end else begin
         r.status = ST_BADSTART;
      end
      return r;
   endfunction

   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic byte_type lead_byte(int len);
      byte_type b;
      b = byte_type'($urandom_range(0, 255));
      case (len)
         1: b[7] = 1'b0;
         2: b[7:5] = 3'b110;
         3: b[7:4] = 4'b1110;
         4: b[7:3] = 5'b11110;
         5: b[7:2] = 6'b111110;
         default: b[7:1] = 7'b1111110;
      endcase
      return b;
   endfunction

   function automatic byte_type cont_byte();
      byte_type b;
      b = byte_type'($urandom_range(0, 255));
      b[7:6] = 2'b10;
      return b;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // one byte, held until the transfer; the expectation is queued at the transfer edge
   task automatic send_byte(input byte_type b);
      int gap;
      gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
      if (gap > 0 && req_valid) begin
         req_valid <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_queue.push_back(decode_next_byte(b));
      bytes_sent++;
   endtask

   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (decode_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_char(input int len);
      send_byte(lead_byte(len));
      repeat (len - 1) send_byte(cont_byte());
   endtask

   task automatic send_broken_char();
      int       len;
      byte_type b;
      len = $urandom_range(2, 6);
      send_byte(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
      b = byte_type'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      send_byte(b);
   endtask

   task automatic send_random_unit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) send_char($urandom_range(1, 6));
      else if (pick < 90) send_broken_char();
      else send_byte(byte_type'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left == 0 && stall_mode == STALL_RANDOM && $urandom_range(0, 99) < 20)
         stall_left = pick_idle_len();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      decode_type want;
      if (!reset && req_valid && req_stall) stalled_offers++;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (decode_queue.size() == 0) begin
            report_mismatch($sformatf("result status %0d code point %h with nothing expected",
                                      rsp_status, rsp_code_point));
         end else begin
            want = decode_queue.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_code_point !== want.code_point)
               report_mismatch($sformatf("code point %h, expected %h",
                                         rsp_code_point, want.code_point));
         end
      end
   end

   task automatic test_single_bytes();
      byte_type list[$];
      list = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF};
      foreach (list[i]) send_byte(list[i]);
   endtask

   task automatic test_full_sequences();
      byte_type list[$];
      list = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
               8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF};
      foreach (list[i]) send_byte(list[i]);
   endtask

   task automatic test_broken_sequences();
      byte_type list[$];
      // a lead byte inside an open sequence is dropped, then decoding starts fresh
      list = '{8'hE0, 8'hC3, 8'h41, 8'hF8, 8'h80, 8'hFF};
      foreach (list[i]) send_byte(list[i]);
   endtask

   task automatic test_random_stream(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         if ((bytes_sent - start) % 60 < 8) begin
            gaps_on    = ($urandom_range(0, 3) != 0);
            stall_mode = ($urandom_range(0, 3) != 0) ? STALL_RANDOM : STALL_NONE;
         end
         send_random_unit();
      end
   endtask

   task automatic test_backpressure_fill();
      gaps_on      = 1'b0;
      stall_mode   = STALL_NONE;
      hold_request = HOLD_CYCLES;
      repeat (8) send_char($urandom_range(2, 6));
      wait_drained();
   endtask

   task automatic test_drain_pause();
      int start;
      gaps_on    = 1'b1;
      stall_mode = STALL_RANDOM;
      repeat (3) begin
         start = bytes_sent;
         while (bytes_sent - start < 18) send_random_unit();
         wait_drained();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_bytes();
      test_full_sequences();
      test_broken_sequences();
      test_random_stream(250);
      test_backpressure_fill();
      test_drain_pause();
      test_random_stream(200);
      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d bytes in %0d cycles, %0d cycles with the input held off",
               bytes_sent, cycle_count, stalled_offers);
      $display("results: %0d ready, %0d need more, %0d incomplete, %0d bad start",
               status_seen[ST_READY], status_seen[ST_MORE],
               status_seen[ST_INCOMPLETE], status_seen[ST_BADSTART]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
